FILE: sv/prpu_pkg.sv
// shared types, register indexes and fixed-point helpers for the radtan camera pipeline
package prpu_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_FOCAL_X = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y = 3'd1;
	localparam logic [2:0] REG_CENTER_X = 3'd2;
	localparam logic [2:0] REG_CENTER_Y = 3'd3;
	localparam logic [2:0] REG_RADIAL_K1 = 3'd4;
	localparam logic [2:0] REG_RADIAL_K2 = 3'd5;
	localparam logic [2:0] REG_TANGENTIAL_P1 = 3'd6;
	localparam logic [2:0] REG_TANGENTIAL_P2 = 3'd7;

	// operation and status codes
	localparam logic FN_UNPROJECT = 1'b0;
	localparam logic FN_PROJECT = 1'b1;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DEPTH = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;
	localparam int DIV_BITS = 32;
	localparam int DST_STEPS = 7;
	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// input and result words
	typedef struct packed {
		logic func;
		logic signed [31:0] pixel_x;
		logic signed [31:0] pixel_y;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result_x;
		logic signed [31:0] result_y;
		logic [1:0] status;
	} out_t;

	// value with its saturation flag
	typedef struct packed {
		logic sat;
		logic signed [31:0] v;
	} qv_t;

	// numerator selection stage
	typedef struct packed {
		logic valid;
		logic func;
		logic zbad;
		logic signed [32:0] numx;
		logic signed [32:0] numy;
		logic [31:0] dvx;
		logic [31:0] dvy;
	} pr_t;

	// restoring divider stage, both lanes
	typedef struct packed {
		logic valid;
		logic func;
		logic zbad;
		logic negx;
		logic negy;
		logic ovx;
		logic ovy;
		logic [31:0] remx;
		logic [31:0] remy;
		logic [31:0] lowx;
		logic [31:0] lowy;
		logic [31:0] qx;
		logic [31:0] qy;
		logic [31:0] dvx;
		logic [31:0] dvy;
	} dv_t;

	// distortion stage; later steps fill more of the temporaries
	typedef struct packed {
		logic valid;
		logic func;
		logic zbad;
		logic sat;
		logic isat;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] xx;
		logic signed [31:0] yy;
		logic signed [31:0] xy;
		logic signed [31:0] r2;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] pxy1;
		logic signed [31:0] pxy2;
		logic signed [31:0] k1r2;
		logic signed [31:0] k2r2;
		logic signed [31:0] txa;
		logic signed [31:0] tya;
		logic signed [31:0] t1;
		logic signed [31:0] t2;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] rad;
		logic signed [31:0] mx;
		logic signed [31:0] my;
	} dst_t;

	// pixel conversion stage
	typedef struct packed {
		logic valid;
		logic func;
		logic zbad;
		logic sat;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [64:0] prx;
		logic signed [64:0] pry;
	} px_t;

	function automatic logic signed [63:0] s64(input logic signed [31:0] a);
		return $signed({{32{a[31]}}, a});
	endfunction

	function automatic qv_t sat32(input logic signed [63:0] v);
		qv_t r;
		r.sat = 1'b0;
		r.v = v[31:0];
		if (v > 64'sd2147483647) begin
			r.sat = 1'b1;
			r.v = S32_MAX;
		end else if (v < -64'sd2147483648) begin
			r.sat = 1'b1;
			r.v = S32_MIN;
		end
		return r;
	endfunction

	// Q4.28 product, round half up, saturate
	function automatic qv_t qmul(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [63:0] p;
		p = s64(a) * s64(b);
		p = p + 64'sd134217728;
		return sat32(p >>> 28);
	endfunction

	function automatic qv_t qadd(input logic signed [31:0] a, input logic signed [31:0] b);
		return sat32(s64(a) + s64(b));
	endfunction

	function automatic qv_t qsub(input logic signed [31:0] a, input logic signed [31:0] b);
		return sat32(s64(a) - s64(b));
	endfunction

	function automatic logic [31:0] focal_of(input logic [31:0] f);
		return (f == 32'd0) ? 32'd1 : f;
	endfunction

	// one quotient bit per lane
	function automatic dv_t divstep(input dv_t i);
		dv_t o;
		logic [32:0] tx;
		logic [32:0] ty;
		logic gx;
		logic gy;
		o = i;
		tx = {i.remx, i.lowx[31]};
		ty = {i.remy, i.lowy[31]};
		gx = tx >= {1'b0, i.dvx};
		gy = ty >= {1'b0, i.dvy};
		o.remx = gx ? 32'(tx - {1'b0, i.dvx}) : tx[31:0];
		o.remy = gy ? 32'(ty - {1'b0, i.dvy}) : ty[31:0];
		o.lowx = {i.lowx[30:0], 1'b0};
		o.lowy = {i.lowy[30:0], 1'b0};
		o.qx = {i.qx[30:0], gx};
		o.qy = {i.qy[30:0], gy};
		return o;
	endfunction

	// apply sign to quotient magnitude and saturate
	function automatic qv_t qfin(input logic neg, input logic ov, input logic [31:0] q);
		qv_t r;
		r.sat = 1'b0;
		r.v = neg ? -$signed(q) : $signed(q);
		if (neg && (ov || q > 32'h8000_0000)) begin
			r.sat = 1'b1;
			r.v = S32_MIN;
		end else if (!neg && (ov || q[31])) begin
			r.sat = 1'b1;
			r.v = S32_MAX;
		end
		return r;
	endfunction

	// one step of a distortion pass
	function automatic dst_t dstep(input logic [2:0] st, input dst_t i,
		input logic signed [31:0] k1, input logic signed [31:0] k2,
		input logic signed [31:0] p1, input logic signed [31:0] p2, input logic act);
		dst_t o;
		qv_t a;
		qv_t b;
		qv_t c;
		qv_t d;
		qv_t e;
		qv_t f;
		qv_t g;
		o = i;
		a = '0;
		b = '0;
		c = '0;
		d = '0;
		e = '0;
		f = '0;
		g = '0;
		case (st)
			3'd0: begin
				a = qmul(i.rx, i.rx);
				b = qmul(i.ry, i.ry);
				c = qmul(i.rx, i.ry);
				o.xx = a.v;
				o.yy = b.v;
				o.xy = c.v;
				o.isat = a.sat | b.sat | c.sat;
			end
			3'd1: begin
				a = qadd(i.xx, i.yy);
				b = qadd(i.xx, i.xx);
				c = qadd(i.yy, i.yy);
				d = qadd(a.v, b.v);
				e = qadd(a.v, c.v);
				f = qmul(p1, i.xy);
				g = qmul(p2, i.xy);
				o.r2 = a.v;
				o.sx = d.v;
				o.sy = e.v;
				o.pxy1 = f.v;
				o.pxy2 = g.v;
				o.isat = i.isat | a.sat | b.sat | c.sat | d.sat | e.sat | f.sat | g.sat;
			end
			3'd2: begin
				a = qmul(k1, i.r2);
				b = qmul(k2, i.r2);
				c = qmul(p2, i.sx);
				d = qmul(p1, i.sy);
				e = qadd(i.pxy1, i.pxy1);
				f = qadd(i.pxy2, i.pxy2);
				o.k1r2 = a.v;
				o.k2r2 = b.v;
				o.txa = c.v;
				o.tya = d.v;
				o.t1 = e.v;
				o.t2 = f.v;
				o.isat = i.isat | a.sat | b.sat | c.sat | d.sat | e.sat | f.sat;
			end
			3'd3: begin
				a = qmul(i.k2r2, i.r2);
				b = qadd(i.txa, i.t1);
				c = qadd(i.tya, i.t2);
				o.k2r2 = a.v;
				o.tx = b.v;
				o.ty = c.v;
				o.isat = i.isat | a.sat | b.sat | c.sat;
			end
			3'd4: begin
				a = qadd(i.k1r2, i.k2r2);
				o.rad = a.v;
				o.isat = i.isat | a.sat;
			end
			3'd5: begin
				a = qmul(i.rx, i.rad);
				b = qmul(i.ry, i.rad);
				o.mx = a.v;
				o.my = b.v;
				o.isat = i.isat | a.sat | b.sat;
			end
			3'd6: begin
				a = qadd(i.mx, i.tx);
				b = qadd(i.my, i.ty);
				c = (i.func == FN_PROJECT) ? qadd(i.cx, a.v) : qsub(i.cx, a.v);
				d = (i.func == FN_PROJECT) ? qadd(i.cy, b.v) : qsub(i.cy, b.v);
				if (act) begin
					o.rx = c.v;
					o.ry = d.v;
					o.sat = i.sat | i.isat | a.sat | b.sat | c.sat | d.sat;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

endpackage

FILE: sv/pinhole_radtan_project_unproject.sv
// pinhole camera with radial-tangential distortion, project and unproject pipeline
//
// channel   direction  handshake              word
// command   in         start, busy            cmd (in_t)
// result    out        done                   result (out_t)
// config    in         cfg_we, cfg_index      cfg_data
//
// One word enters per cycle and passes through, in order:
// 2 prep stages, 32 divider stages (one quotient bit each), 1 sign stage,
// 7 stages per distortion pass, 2 pixel stages and the output register.
// busy stays low: nothing in the pipeline ever holds, and done pulses once per word.
// Reset clears all valid bits and loads the register defaults.
module pinhole_radtan_project_unproject #(
	parameter int UNDISTORT_ITERATIONS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  prpu_pkg::in_t cmd,
	output logic done,
	output prpu_pkg::out_t result,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import prpu_pkg::*;

	localparam int NDST = DST_STEPS * UNDISTORT_ITERATIONS;

	logic [31:0] focal_x_q;
	logic [31:0] focal_y_q;
	logic signed [31:0] center_x_q;
	logic signed [31:0] center_y_q;
	logic signed [31:0] radial_k1_q;
	logic signed [31:0] radial_k2_q;
	logic signed [31:0] tangential_p1_q;
	logic signed [31:0] tangential_p2_q;
	logic use_dist;

	pr_t prep_s1;
	pr_t prep_d;
	dv_t div_s [DIV_BITS+1];
	dv_t div_d;
	dst_t dst_s [NDST+1];
	dst_t dst_d;
	px_t pix_s1;
	px_t pix_s2;
	px_t pix1_d;
	px_t pix2_d;
	logic done_q;
	out_t result_q;
	out_t result_d;

	assign busy = 1'b0;
	assign use_dist = radial_k1_q != 32'sd0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= FOCAL_RESET;
			focal_y_q <= FOCAL_RESET;
			center_x_q <= '0;
			center_y_q <= '0;
			radial_k1_q <= '0;
			radial_k2_q <= '0;
			tangential_p1_q <= '0;
			tangential_p2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOCAL_X: focal_x_q <= cfg_data;
				REG_FOCAL_Y: focal_y_q <= cfg_data;
				REG_CENTER_X: center_x_q <= $signed(cfg_data);
				REG_CENTER_Y: center_y_q <= $signed(cfg_data);
				REG_RADIAL_K1: radial_k1_q <= $signed(cfg_data);
				REG_RADIAL_K2: radial_k2_q <= $signed(cfg_data);
				REG_TANGENTIAL_P1: tangential_p1_q <= $signed(cfg_data);
				REG_TANGENTIAL_P2: tangential_p2_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// numerator and divisor selection
	always_comb begin
		prep_d.valid = start;
		prep_d.func = cmd.func;
		prep_d.zbad = cmd.point_z[31] | (cmd.point_z == 32'sd0);
		if (cmd.func == FN_UNPROJECT) begin
			prep_d.numx = $signed({cmd.pixel_x[31], cmd.pixel_x})
				- $signed({center_x_q[31], center_x_q});
			prep_d.numy = $signed({cmd.pixel_y[31], cmd.pixel_y})
				- $signed({center_y_q[31], center_y_q});
			prep_d.dvx = focal_of(focal_x_q);
			prep_d.dvy = focal_of(focal_y_q);
		end else begin
			prep_d.numx = $signed({cmd.point_x[31], cmd.point_x});
			prep_d.numy = $signed({cmd.point_y[31], cmd.point_y});
			prep_d.dvx = prep_d.zbad ? 32'd1 : cmd.point_z;
			prep_d.dvy = prep_d.zbad ? 32'd1 : cmd.point_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_s1 <= '0;
		end else begin
			prep_s1 <= prep_d;
		end
	end

	// magnitudes, early overflow test and divider seed
	always_comb begin
		logic [32:0] ax;
		logic [32:0] ay;
		ax = prep_s1.numx[32] ? 33'(-prep_s1.numx) : prep_s1.numx;
		ay = prep_s1.numy[32] ? 33'(-prep_s1.numy) : prep_s1.numy;
		div_d.valid = prep_s1.valid;
		div_d.func = prep_s1.func;
		div_d.zbad = prep_s1.zbad;
		div_d.negx = prep_s1.numx[32];
		div_d.negy = prep_s1.numy[32];
		div_d.ovx = {4'b0, ax[31:0]} >= {prep_s1.dvx, 4'b0};
		div_d.ovy = {4'b0, ay[31:0]} >= {prep_s1.dvy, 4'b0};
		div_d.remx = {4'b0, ax[31:4]};
		div_d.remy = {4'b0, ay[31:4]};
		div_d.lowx = {ax[3:0], 28'b0};
		div_d.lowy = {ay[3:0], 28'b0};
		div_d.qx = '0;
		div_d.qy = '0;
		div_d.dvx = prep_s1.dvx;
		div_d.dvy = prep_s1.dvy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0] <= '0;
		end else begin
			div_s[0] <= div_d;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[k+1] <= '0;
			end else begin
				div_s[k+1] <= divstep(div_s[k]);
			end
		end
	end

	// signed quotient, start point of the distortion passes
	always_comb begin
		qv_t nx;
		qv_t ny;
		nx = qfin(div_s[DIV_BITS].negx, div_s[DIV_BITS].ovx, div_s[DIV_BITS].qx);
		ny = qfin(div_s[DIV_BITS].negy, div_s[DIV_BITS].ovy, div_s[DIV_BITS].qy);
		dst_d = '0;
		dst_d.valid = div_s[DIV_BITS].valid;
		dst_d.func = div_s[DIV_BITS].func;
		dst_d.zbad = div_s[DIV_BITS].zbad;
		dst_d.sat = nx.sat | ny.sat;
		dst_d.cx = nx.v;
		dst_d.cy = ny.v;
		dst_d.rx = nx.v;
		dst_d.ry = ny.v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_s[0] <= '0;
		end else begin
			dst_s[0] <= dst_d;
		end
	end

	// distortion passes, active only while radial_k1 is nonzero: project uses the first, unproject all of them
	for (genvar j = 0; j < NDST; j++) begin : g_dst
		localparam int PASS = j / DST_STEPS;
		logic act;
		assign act = use_dist & ((dst_s[j].func == FN_UNPROJECT) | (PASS == 0));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dst_s[j+1] <= '0;
			end else begin
				dst_s[j+1] <= dstep(3'(j % DST_STEPS), dst_s[j], radial_k1_q, radial_k2_q,
					tangential_p1_q, tangential_p2_q, act);
			end
		end
	end

	// focal length products
	always_comb begin
		pix1_d = '0;
		pix1_d.valid = dst_s[NDST].valid;
		pix1_d.func = dst_s[NDST].func;
		pix1_d.zbad = dst_s[NDST].zbad;
		pix1_d.sat = dst_s[NDST].sat;
		pix1_d.rx = dst_s[NDST].rx;
		pix1_d.ry = dst_s[NDST].ry;
		pix1_d.prx = $signed({{33{dst_s[NDST].rx[31]}}, dst_s[NDST].rx})
			* $signed({33'b0, focal_of(focal_x_q)});
		pix1_d.pry = $signed({{33{dst_s[NDST].ry[31]}}, dst_s[NDST].ry})
			* $signed({33'b0, focal_of(focal_y_q)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= '0;
		end else begin
			pix_s1 <= pix1_d;
		end
	end

	// project only: round, add principal point, saturate
	always_comb begin
		logic signed [65:0] tx;
		logic signed [65:0] ty;
		logic signed [65:0] wx;
		logic signed [65:0] wy;
		qv_t px;
		qv_t py;
		tx = $signed({pix_s1.prx[64], pix_s1.prx}) + 66'sd134217728;
		ty = $signed({pix_s1.pry[64], pix_s1.pry}) + 66'sd134217728;
		wx = tx >>> 28;
		wy = ty >>> 28;
		px = sat32($signed(wx[63:0]) + s64(center_x_q));
		py = sat32($signed(wy[63:0]) + s64(center_y_q));
		pix2_d = pix_s1;
		pix2_d.prx = '0;
		pix2_d.pry = '0;
		if (pix_s1.func == FN_PROJECT) begin
			pix2_d.rx = px.v;
			pix2_d.ry = py.v;
			pix2_d.sat = pix_s1.sat | px.sat | py.sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s2 <= '0;
		end else begin
			pix_s2 <= pix2_d;
		end
	end

	// result word and status
	always_comb begin
		result_d.result_x = pix_s2.rx;
		result_d.result_y = pix_s2.ry;
		result_d.status = pix_s2.sat ? ST_SAT : ST_OK;
		if ((pix_s2.func == FN_PROJECT) && pix_s2.zbad) begin
			result_d.result_x = '0;
			result_d.result_y = '0;
			result_d.status = ST_DEPTH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= pix_s2.valid;
			result_q <= result_d;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule
